// ----- sv/polyline_arc_length_locator_defines.svh -----
// Assertion macros used by the checker file.
`ifndef POLYLINE_ARC_LENGTH_LOCATOR_DEFINES_SVH
`define POLYLINE_ARC_LENGTH_LOCATOR_DEFINES_SVH

// Antecedent holds in this cycle, consequent in the same cycle.
`define PALL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pall check failed");

// Antecedent holds in this cycle, consequent in the next cycle.
`define PALL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pall check failed");

`endif

// ----- sv/pall_pkg.sv -----
package pall_pkg;

  typedef enum logic [2:0] {
    ST_APPENDED = 3'd0,
    ST_INSIDE   = 3'd1,
    ST_BEFORE   = 3'd2,
    ST_BEYOND   = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  localparam int unsigned CNT_W      = 6;
  localparam int unsigned SQ_STEPS   = 4;
  localparam int unsigned SUMSQ_W    = 68;
  localparam int unsigned ROOT_W     = 34;
  localparam int unsigned ROOT_STEPS = 34;
  localparam int unsigned RREM_W     = 36;
  localparam int unsigned LEN_W      = 48;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [15:0]        tag;
    logic [47:0]        offset;
    logic [47:0]        len;
  } point_t;

  typedef struct packed {
    logic accept;
    logic rd_prev;
    logic sq_step;
    logic root_init;
    logic root_step;
    logic wr_point;
    logic srch_issue;
    logic srch_update;
    logic rd_a;
    logic rd_b;
    logic div_init;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic empty;
    logic full;
    logic sq_last;
    logic root_last;
    logic div_last;
    logic srch_done;
    logic out_busy;
  } sts_t;

endpackage

// ----- sv/polyline_arc_length_locator.sv -----
// Channel  | Direction | Handshake               | Payload
// input    | in        | in_valid_i / in_stall_o | kind, coords, tag, offset, query distance
// result   | out       | out_valid_o/out_stall_i | status, index, position, direction, total
//
// One item at a time. Append: sum of squares, then the 34-step square root.
// Query: binary search on the point memory read port, then FRACTION_BITS
// divide/interpolate steps.
// Reset clears the point count and control; point memory is not cleared.
// A stalled result holds; the next item may be taken while it waits.
module polyline_arc_length_locator #(
  parameter int unsigned MAX_POINTS    = 256,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic signed [31:0] x_coord_i,
  input  logic signed [31:0] y_coord_i,
  input  logic signed [31:0] z_coord_i,
  input  logic [15:0]        resource_tag_i,
  input  logic [47:0]        resource_offset_i,
  input  logic signed [47:0] query_distance_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic signed [9:0]  index_whole_o,
  output logic [15:0]        index_fraction_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic [47:0]        out_resource_offset_o,
  output logic [15:0]        out_resource_tag_o,
  output logic signed [32:0] dir_x_o,
  output logic signed [32:0] dir_y_o,
  output logic signed [32:0] dir_z_o,
  output logic [47:0]        total_length_o
);
  import pall_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pall_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pall_dpath #(
    .MAX_POINTS    (MAX_POINTS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dpath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .kind_i                (kind_i),
    .x_coord_i             (x_coord_i),
    .y_coord_i             (y_coord_i),
    .z_coord_i             (z_coord_i),
    .resource_tag_i        (resource_tag_i),
    .resource_offset_i     (resource_offset_i),
    .query_distance_i      (query_distance_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .status_o              (status_o),
    .index_whole_o         (index_whole_o),
    .index_fraction_o      (index_fraction_o),
    .out_x_o               (out_x_o),
    .out_y_o               (out_y_o),
    .out_z_o               (out_z_o),
    .out_resource_offset_o (out_resource_offset_o),
    .out_resource_tag_o    (out_resource_tag_o),
    .dir_x_o               (dir_x_o),
    .dir_y_o               (dir_y_o),
    .dir_z_o               (dir_z_o),
    .total_length_o        (total_length_o)
  );

endmodule

// ----- sv/pall_ctrl.sv -----
module pall_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pall_pkg::sts_t sts_i,
  output pall_pkg::cmd_t cmd_o
);
  import pall_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_DISP    = 14'b00000000000010,
    S_RDPREV  = 14'b00000000000100,
    S_SQ      = 14'b00000000001000,
    S_RTINIT  = 14'b00000000010000,
    S_ROOT    = 14'b00000000100000,
    S_WRITE   = 14'b00000001000000,
    S_SRCH    = 14'b00000010000000,
    S_SCMP    = 14'b00000100000000,
    S_RDA     = 14'b00001000000000,
    S_RDB     = 14'b00010000000000,
    S_DIVINIT = 14'b00100000000000,
    S_DIV     = 14'b01000000000000,
    S_FIN     = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.is_query) begin
          state_d = sts_i.empty ? S_FIN : S_SRCH;
        end else if (sts_i.full) begin
          state_d = S_FIN;
        end else begin
          state_d = sts_i.empty ? S_WRITE : S_RDPREV;
        end
      end
      S_RDPREV: begin
        cmd_o.rd_prev = 1'b1;
        state_d       = S_SQ;
      end
      S_SQ: begin
        cmd_o.sq_step = 1'b1;
        if (sts_i.sq_last) state_d = S_RTINIT;
      end
      S_RTINIT: begin
        cmd_o.root_init = 1'b1;
        state_d         = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.root_last) state_d = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.wr_point = 1'b1;
        state_d        = S_FIN;
      end
      S_SRCH: begin
        if (sts_i.srch_done) begin
          state_d = S_RDA;
        end else begin
          cmd_o.srch_issue = 1'b1;
          state_d          = S_SCMP;
        end
      end
      S_SCMP: begin
        cmd_o.srch_update = 1'b1;
        state_d           = S_SRCH;
      end
      S_RDA: begin
        cmd_o.rd_a = 1'b1;
        state_d    = S_RDB;
      end
      S_RDB: begin
        cmd_o.rd_b = 1'b1;
        state_d    = S_DIVINIT;
      end
      S_DIVINIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ----- sv/pall_dpath.sv -----
module pall_dpath #(
  parameter int unsigned MAX_POINTS    = 256,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pall_pkg::cmd_t      cmd_i,
  output pall_pkg::sts_t      sts_o,
  input  logic                kind_i,
  input  logic signed [31:0]  x_coord_i,
  input  logic signed [31:0]  y_coord_i,
  input  logic signed [31:0]  z_coord_i,
  input  logic [15:0]         resource_tag_i,
  input  logic [47:0]         resource_offset_i,
  input  logic signed [47:0]  query_distance_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          status_o,
  output logic signed [9:0]   index_whole_o,
  output logic [15:0]         index_fraction_o,
  output logic signed [31:0]  out_x_o,
  output logic signed [31:0]  out_y_o,
  output logic signed [31:0]  out_z_o,
  output logic [47:0]         out_resource_offset_o,
  output logic [15:0]         out_resource_tag_o,
  output logic signed [32:0]  dir_x_o,
  output logic signed [32:0]  dir_y_o,
  output logic signed [32:0]  dir_z_o,
  output logic [47:0]         total_length_o
);
  import pall_pkg::*;

  localparam int unsigned AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned FB    = FRACTION_BITS;
  localparam int unsigned ACC_W = 32 + FB;
  localparam int unsigned ACO_W = 48 + FB;

  function automatic logic [31:0] mag33(input logic [32:0] d);
    mag33 = d[32] ? 32'(-d) : d[31:0];
  endfunction

  function automatic logic [47:0] mag49(input logic [48:0] d);
    mag49 = d[48] ? 48'(-d) : d[47:0];
  endfunction

  point_t mem [MAX_POINTS];
  point_t rd_q, a_q, b_q;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  logic              kind_q;
  point_t            in_q;
  logic signed [47:0] q_q;
  logic              full_q;

  logic [CW-1:0]  count_q;
  logic [LEN_W-1:0] total_q;
  logic [CNT_W-1:0] cnt_q;

  logic [63:0]          prod_q;
  logic [SUMSQ_W-1:0]   sum_q;
  logic [SUMSQ_W-1:0]   rad_q;
  logic [RREM_W-1:0]    rrem_q;
  logic [ROOT_W-1:0]    root_q;

  logic [CW-1:0] lo_q, hi_q, mid;

  logic [47:0]       drem_q, span_q;
  logic [FB-1:0]     f_q;
  logic [31:0]       mx_q, my_q, mz_q;
  logic [47:0]       mo_q;
  logic              nx_q, ny_q, nz_q, no_q;
  logic [ACC_W-1:0]  ax_q, ay_q, az_q;
  logic [ACO_W-1:0]  ao_q;

  logic out_valid_q;

  // ---- status ----
  logic is_before, is_beyond;
  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign is_beyond = (lo_q == count_q);
  assign is_before = (lo_q == '0);

  always_comb begin
    sts_o           = '0;
    sts_o.is_query  = kind_q;
    sts_o.empty     = (count_q == '0);
    sts_o.full      = full_q;
    sts_o.sq_last   = (cnt_q == CNT_W'(SQ_STEPS - 1));
    sts_o.root_last = (cnt_q == CNT_W'(ROOT_STEPS - 1));
    sts_o.div_last  = (cnt_q == CNT_W'(FB - 1));
    sts_o.srch_done = (lo_q >= hi_q);
    sts_o.out_busy  = out_valid_q & out_stall_i;
  end

  // ---- memory ----
  logic [CW-1:0] base_idx, other_idx;
  always_comb begin
    if (is_beyond) begin
      base_idx  = count_q - CW'(1);
      other_idx = count_q - CW'(2);
    end else if (is_before) begin
      base_idx  = '0;
      other_idx = CW'(1);
    end else begin
      base_idx  = lo_q - CW'(1);
      other_idx = lo_q;
    end
  end

  always_comb begin
    rd_en   = cmd_i.rd_prev | cmd_i.srch_issue | cmd_i.rd_a | cmd_i.rd_b;
    rd_addr = '0;
    if (cmd_i.rd_prev)    rd_addr = AW'(count_q - CW'(1));
    if (cmd_i.srch_issue) rd_addr = mid[AW-1:0];
    if (cmd_i.rd_a)       rd_addr = base_idx[AW-1:0];
    if (cmd_i.rd_b)       rd_addr = other_idx[AW-1:0];
  end

  logic [48:0]      len_sum;
  logic [LEN_W-1:0] new_len;
  point_t           wr_rec;
  assign len_sum = 49'(total_q) + 49'(root_q);
  always_comb begin
    if (count_q == '0)   new_len = '0;
    else if (len_sum[48]) new_len = '1;
    else                  new_len = len_sum[47:0];
    wr_rec     = in_q;
    wr_rec.len = new_len;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_point) mem[count_q[AW-1:0]] <= wr_rec;
    if (rd_en)          rd_q <= mem[rd_addr];
  end

  // ---- input latch, count, counters ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
      cnt_q   <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      kind_q  <= 1'b0;
      full_q  <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        kind_q <= kind_i;
        full_q <= (count_q == CW'(MAX_POINTS));
        lo_q   <= '0;
        hi_q   <= count_q;
      end
      if (cmd_i.accept || cmd_i.root_init || cmd_i.div_init) begin
        cnt_q <= '0;
      end else if (cmd_i.sq_step || cmd_i.root_step || cmd_i.div_step) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.wr_point) begin
        count_q <= count_q + CW'(1);
        total_q <= new_len;
      end
      if (cmd_i.srch_update) begin
        if ($signed({1'b0, rd_q.len}) > $signed({q_q[47], q_q})) hi_q <= mid;
        else lo_q <= mid + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      in_q.x      <= x_coord_i;
      in_q.y      <= y_coord_i;
      in_q.z      <= z_coord_i;
      in_q.tag    <= resource_tag_i;
      in_q.offset <= resource_offset_i;
      in_q.len    <= '0;
      q_q         <= query_distance_i;
    end
  end

  // ---- segment length: squares then square root ----
  logic [32:0] sq_d;
  logic [31:0] sq_m;
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    sq_d = {in_q.x[31], in_q.x} - {rd_q.x[31], rd_q.x};
      2'd1:    sq_d = {in_q.y[31], in_q.y} - {rd_q.y[31], rd_q.y};
      default: sq_d = {in_q.z[31], in_q.z} - {rd_q.z[31], rd_q.z};
    endcase
    sq_m = mag33(sq_d);
  end

  logic [RREM_W+1:0] rt_cur, rt_try;
  logic              rt_ge;
  assign rt_cur = {rrem_q, rad_q[SUMSQ_W-1 -: 2]};
  assign rt_try = {2'b00, root_q, 2'b01};
  assign rt_ge  = (rt_cur >= rt_try);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_step) begin
      prod_q <= sq_m * sq_m;
      sum_q  <= (cnt_q == '0) ? '0 : sum_q + SUMSQ_W'(prod_q);
    end
    if (cmd_i.root_init) begin
      rad_q  <= sum_q;
      rrem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= rad_q << 2;
      rrem_q <= rt_ge ? RREM_W'(rt_cur - rt_try) : RREM_W'(rt_cur);
      root_q <= {root_q[ROOT_W-2:0], rt_ge};
    end
  end

  // ---- fraction division fused with interpolation multiply ----
  logic [48:0] dv_cur;
  logic        dv_bit;
  assign dv_cur = {drem_q, 1'b0};
  assign dv_bit = (dv_cur >= {1'b0, span_q});

  logic [32:0] dfx, dfy, dfz;
  logic [48:0] dfo;
  logic [48:0] rem_init;
  assign dfx      = {rd_q.x[31], rd_q.x} - {a_q.x[31], a_q.x};
  assign dfy      = {rd_q.y[31], rd_q.y} - {a_q.y[31], a_q.y};
  assign dfz      = {rd_q.z[31], rd_q.z} - {a_q.z[31], a_q.z};
  assign dfo      = {1'b0, rd_q.offset} - {1'b0, a_q.offset};
  assign rem_init = {q_q[47], q_q} - {1'b0, a_q.len};

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_b) a_q <= rd_q;
    if (cmd_i.div_init) begin
      b_q    <= rd_q;
      drem_q <= rem_init[47:0];
      span_q <= rd_q.len - a_q.len;
      f_q    <= '0;
      mx_q   <= mag33(dfx);
      my_q   <= mag33(dfy);
      mz_q   <= mag33(dfz);
      mo_q   <= mag49(dfo);
      nx_q   <= dfx[32];
      ny_q   <= dfy[32];
      nz_q   <= dfz[32];
      no_q   <= dfo[48];
      ax_q   <= '0;
      ay_q   <= '0;
      az_q   <= '0;
      ao_q   <= '0;
    end else if (cmd_i.div_step) begin
      drem_q <= dv_bit ? 48'(dv_cur - {1'b0, span_q}) : dv_cur[47:0];
      f_q    <= {f_q[FB-2:0], dv_bit};
      ax_q   <= (ax_q << 1) + (dv_bit ? ACC_W'(mx_q) : '0);
      ay_q   <= (ay_q << 1) + (dv_bit ? ACC_W'(my_q) : '0);
      az_q   <= (az_q << 1) + (dv_bit ? ACC_W'(mz_q) : '0);
      ao_q   <= (ao_q << 1) + (dv_bit ? ACO_W'(mo_q) : '0);
    end
  end

  // ---- result register ----
  logic [31:0] tx, ty, tz;
  logic [47:0] to;
  logic [31:0] ix, iy, iz;
  logic [47:0] io;
  assign tx = ax_q[FB +: 32];
  assign ty = ay_q[FB +: 32];
  assign tz = az_q[FB +: 32];
  assign to = ao_q[FB +: 48];
  assign ix = nx_q ? a_q.x - tx : a_q.x + tx;
  assign iy = ny_q ? a_q.y - ty : a_q.y + ty;
  assign iz = nz_q ? a_q.z - tz : a_q.z + tz;
  assign io = no_q ? a_q.offset - to : a_q.offset + to;

  logic        two_pts;
  logic [32:0] dab_x, dab_y, dab_z;
  assign two_pts = (count_q >= CW'(2));
  assign dab_x = {a_q.x[31], a_q.x} - {b_q.x[31], b_q.x};
  assign dab_y = {a_q.y[31], a_q.y} - {b_q.y[31], b_q.y};
  assign dab_z = {a_q.z[31], a_q.z} - {b_q.z[31], b_q.z};

  status_e res_st;
  always_comb begin
    if (!kind_q)        res_st = full_q ? ST_FULL : ST_APPENDED;
    else if (count_q == '0) res_st = ST_EMPTY;
    else if (is_beyond) res_st = ST_BEYOND;
    else if (is_before) res_st = ST_BEFORE;
    else                res_st = ST_INSIDE;
  end

  status_e           o_st_q;
  logic [9:0]        o_idx_q;
  logic [15:0]       o_frac_q;
  logic [31:0]       o_x_q, o_y_q, o_z_q;
  logic [47:0]       o_off_q, o_tot_q;
  logic [15:0]       o_tag_q;
  logic [32:0]       o_dx_q, o_dy_q, o_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      o_st_q   <= res_st;
      o_idx_q  <= '0;
      o_frac_q <= '0;
      o_x_q    <= '0;
      o_y_q    <= '0;
      o_z_q    <= '0;
      o_off_q  <= '0;
      o_tag_q  <= '0;
      o_dx_q   <= '0;
      o_dy_q   <= '0;
      o_dz_q   <= '0;
      o_tot_q  <= total_q;
      case (res_st)
        ST_APPENDED: begin
          o_idx_q <= 10'(count_q - CW'(1));
        end
        ST_EMPTY: begin
          o_tot_q <= '0;
        end
        ST_BEFORE, ST_BEYOND: begin
          o_idx_q <= (res_st == ST_BEFORE) ? 10'h3FF : 10'(count_q);
          o_x_q   <= a_q.x;
          o_y_q   <= a_q.y;
          o_z_q   <= a_q.z;
          o_off_q <= a_q.offset;
          o_tag_q <= a_q.tag;
          if (two_pts) begin
            o_dx_q <= dab_x;
            o_dy_q <= dab_y;
            o_dz_q <= dab_z;
          end
        end
        ST_INSIDE: begin
          o_idx_q  <= 10'(lo_q - CW'(1));
          o_frac_q <= 16'(f_q);
          o_x_q    <= ix;
          o_y_q    <= iy;
          o_z_q    <= iz;
          o_off_q  <= io;
          o_tag_q  <= a_q.tag;
          o_dx_q   <= 33'(-dab_x);
          o_dy_q   <= 33'(-dab_y);
          o_dz_q   <= 33'(-dab_z);
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o           = out_valid_q;
  assign status_o              = o_st_q;
  assign index_whole_o         = o_idx_q;
  assign index_fraction_o      = o_frac_q;
  assign out_x_o               = o_x_q;
  assign out_y_o               = o_y_q;
  assign out_z_o               = o_z_q;
  assign out_resource_offset_o = o_off_q;
  assign out_resource_tag_o    = o_tag_q;
  assign dir_x_o               = o_dx_q;
  assign dir_y_o               = o_dy_q;
  assign dir_z_o               = o_dz_q;
  assign total_length_o        = o_tot_q;

endmodule

// ----- sv/pall_checker.sv -----
`include "polyline_arc_length_locator_defines.svh"

module pall_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [2:0]         status_o,
  input logic signed [9:0]  index_whole_o,
  input logic [15:0]        index_fraction_o,
  input logic signed [32:0] dir_x_o,
  input logic [47:0]        total_length_o
);
  import pall_pkg::*;

  `PALL_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_o))
  `PALL_ASSERT_NOW(a_append_clean, out_valid_o && status_o == ST_APPENDED, index_fraction_o == 16'd0 && dir_x_o == 33'd0)
  `PALL_ASSERT_NOW(a_empty_zero, out_valid_o && status_o == ST_EMPTY, total_length_o == 48'd0 && index_whole_o == 10'sd0)
  `PALL_ASSERT_NOW(a_before_idx, out_valid_o && status_o == ST_BEFORE, index_whole_o == -10'sd1 && index_fraction_o == 16'd0)

endmodule

bind polyline_arc_length_locator pall_checker u_pall_checker (.*);
